/* design/binary_tile_xnor_convolution_macros.svh */
// Assertion macros used by the window engine of the binary tile XNOR convolution RTL.
`ifndef BINARY_TILE_XNOR_CONVOLUTION_MACROS_SVH
`define BINARY_TILE_XNOR_CONVOLUTION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTXC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("btxc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BTXC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("btxc assertion failed");

`endif

/* design/btxc_pkg.sv */
// Package: types, constants and helper functions of the binary tile XNOR convolution.
`default_nettype none

package btxc_pkg;

	localparam int TILE_BITS    = 64;
	localparam int ROW_STRIDE   = 8;
	localparam int DIM_W        = 4;
	localparam int IDX_W        = 3;
	localparam int ROW_CNT_W    = 4;
	localparam int AREA_W       = 7;
	localparam int DOT_W        = 8;
	localparam int QUEUE_DEPTH  = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int TILE_SIDE_DEF = 8;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL_PATTERN = 2'd0,
		REG_KERNEL_WIDTH   = 2'd1,
		REG_KERNEL_HEIGHT  = 2'd2
	} cfg_reg_t;

	// One accepted tile that has at least one window to work through
	typedef struct packed {
		logic [TILE_BITS-1:0] tile;
		logic [IDX_W-1:0]     last_row;
		logic [IDX_W-1:0]     last_col;
	} job_t;

	// Kernel data derived from the configuration registers
	typedef struct packed {
		logic [TILE_BITS-1:0] kern;
		logic [TILE_BITS-1:0] area_mask;
		logic [AREA_W-1:0]    area;
	} kernel_t;

	// Clamp a dimension into [lo, hi]
	function automatic logic [DIM_W-1:0] clamp_dim(
		input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] lo,
		input logic [DIM_W-1:0] hi
	);
		logic [DIM_W-1:0] r;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Ones in one row of eight bits
	function automatic logic [ROW_CNT_W-1:0] popcount8(input logic [ROW_STRIDE-1:0] v);
		logic [ROW_CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < ROW_STRIDE; i++) begin
			n = n + ROW_CNT_W'(v[i]);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

/* design/btxc_front.sv */
// Front end: accepts tiles, clamps their sizes and drops those where no window fits.
`default_nettype none

module btxc_front #(
	parameter int TILE_SIDE = btxc_pkg::TILE_SIDE_DEF
) (
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [btxc_pkg::TILE_BITS-1:0]  tile_bits,
	input  wire logic [btxc_pkg::DIM_W-1:0]      valid_width,
	input  wire logic [btxc_pkg::DIM_W-1:0]      valid_height,
	input  wire logic [btxc_pkg::DIM_W-1:0]      kw,
	input  wire logic [btxc_pkg::DIM_W-1:0]      kh,
	input  wire logic                            queue_full,
	output logic                                 push,
	output btxc_pkg::job_t                       job
);

	logic [btxc_pkg::DIM_W-1:0] vw;
	logic [btxc_pkg::DIM_W-1:0] vh;
	logic [btxc_pkg::DIM_W-1:0] span_row;
	logic [btxc_pkg::DIM_W-1:0] span_col;
	logic                       fits;

	// Clamp the valid area to the tile
	assign vw = btxc_pkg::clamp_dim(valid_width, '0, btxc_pkg::DIM_W'(TILE_SIDE));
	assign vh = btxc_pkg::clamp_dim(valid_height, '0, btxc_pkg::DIM_W'(TILE_SIDE));

	// A tile with a kernel larger than its valid area yields nothing
	assign fits     = (kw <= vw) && (kh <= vh);
	assign span_row = vh - kh;
	assign span_col = vw - kw;

	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full && fits;

	always_comb begin
		job.tile     = tile_bits;
		job.last_row = span_row[btxc_pkg::IDX_W-1:0];
		job.last_col = span_col[btxc_pkg::IDX_W-1:0];
	end

endmodule

`default_nettype wire

/* design/btxc_queue.sv */
// Short job queue between the front end and the window engine.
`default_nettype none

module btxc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire btxc_pkg::job_t  push_job,
	input  wire logic            pop,
	output logic                 full,
	output logic                 head_valid,
	output btxc_pkg::job_t       head
);

	localparam int PTR_W = $clog2(btxc_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(btxc_pkg::QUEUE_DEPTH + 1);

	btxc_pkg::job_t    mem_q [btxc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full       = (count_q == CNT_W'(btxc_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Storage needs no reset
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* design/btxc_back.sv */
// Window engine: walks the windows of each queued tile and computes the XNOR dot products.
`default_nettype none

`include "binary_tile_xnor_convolution_macros.svh"

module btxc_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              head_valid,
	input  wire btxc_pkg::job_t                    head,
	input  wire btxc_pkg::kernel_t                 kcfg,
	output logic                                   pop,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [btxc_pkg::IDX_W-1:0]             window_row,
	output logic [btxc_pkg::IDX_W-1:0]             window_col,
	output logic signed [btxc_pkg::DOT_W-1:0]      dot_value,
	output logic                                   last
);

	localparam int NROWS = btxc_pkg::TILE_BITS / btxc_pkg::ROW_STRIDE;

	// Window position of the current tile
	logic [btxc_pkg::IDX_W-1:0] row_q;
	logic [btxc_pkg::IDX_W-1:0] col_q;

	// Stage 1: per-row match counts
	logic                                        valid_s1;
	logic [btxc_pkg::IDX_W-1:0]                  row_s1;
	logic [btxc_pkg::IDX_W-1:0]                  col_s1;
	logic                                        last_s1;
	logic [NROWS-1:0][btxc_pkg::ROW_CNT_W-1:0]   cnt_s1;

	// Output register
	logic                                        out_valid_q;
	logic [btxc_pkg::IDX_W-1:0]                  out_row_q;
	logic [btxc_pkg::IDX_W-1:0]                  out_col_q;
	logic [btxc_pkg::DOT_W-1:0]                  out_dot_q;
	logic                                        out_last_q;

	logic                                        adv;
	logic                                        issue;
	logic                                        is_last;
	logic [btxc_pkg::TILE_BITS-1:0]              win;
	logic [btxc_pkg::TILE_BITS-1:0]              match;
	logic [NROWS-1:0][btxc_pkg::ROW_CNT_W-1:0]   row_cnt;
	logic [btxc_pkg::AREA_W-1:0]                 sum;
	logic [btxc_pkg::DOT_W-1:0]                  dot;

	// Whole pipeline moves when the output register is free or being drained
	assign adv     = !out_valid_q || out_ready;
	assign issue   = head_valid && adv;
	assign is_last = (row_q == head.last_row) && (col_q == head.last_col);
	assign pop     = issue && is_last;

	// Window select: {row, col} is row*8+col as the row stride is eight
	always_comb begin
		win   = (head.tile >> {row_q, col_q}) & kcfg.area_mask;
		match = ~(win ^ kcfg.kern) & kcfg.area_mask;
		for (int i = 0; i < NROWS; i++) begin
			row_cnt[i] = btxc_pkg::popcount8(
				match[i*btxc_pkg::ROW_STRIDE +: btxc_pkg::ROW_STRIDE]);
		end
	end

	// Sum of the row counts, then 2*matches - area
	always_comb begin
		sum = '0;
		for (int i = 0; i < NROWS; i++) begin
			sum = sum + btxc_pkg::AREA_W'(cnt_s1[i]);
		end
		dot = {sum, 1'b0} - {1'b0, kcfg.area};
	end

	// Window iterator, row-major
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (issue) begin
			if (col_q == head.last_col) begin
				col_q <= '0;
				if (row_q == head.last_row) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + btxc_pkg::IDX_W'(1);
				end
			end else begin
				col_q <= col_q + btxc_pkg::IDX_W'(1);
			end
		end
	end

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= issue;
			out_valid_q <= valid_s1;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (issue) begin
			row_s1  <= row_q;
			col_s1  <= col_q;
			last_s1 <= is_last;
			cnt_s1  <= row_cnt;
		end
		if (adv && valid_s1) begin
			out_row_q  <= row_s1;
			out_col_q  <= col_s1;
			out_dot_q  <= dot;
			out_last_q <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign window_row = out_row_q;
	assign window_col = out_col_q;
	assign dot_value  = $signed(out_dot_q);
	assign last       = out_last_q;

	// Iterator never leaves the window range of the tile at the head
	`BTXC_ASSERT_SAME(a_iter_in_range, clk, arst_n, head_valid,
		(row_q <= head.last_row) && (col_q <= head.last_col))
	// The final window of a tile reaches stage 1 flagged as last
	`BTXC_ASSERT_NEXT(a_last_tracked, clk, arst_n, pop, valid_s1 && last_s1)
	// Dot product stays within plus or minus the largest kernel area
	`BTXC_ASSERT_SAME(a_dot_range, clk, arst_n, out_valid_q,
		($signed(out_dot_q) <= 8'sd64) && ($signed(out_dot_q) >= -8'sd64))

endmodule

`default_nettype wire

/* design/binary_tile_xnor_convolution.sv */
// Binary tile XNOR convolution: top level with configuration registers.
//
// Usage: a tile of 8x8 sign bits (bit row*8+col) comes in on the in_valid/in_ready
// channel with its valid width and height. For every window position where the
// configured kernel fits inside the valid area, one result leaves on the
// out_valid/out_ready channel in row-major order: window_row, window_col,
// dot_value = 2*matches - kernel area, and last on the final window of the tile.
// A tile where no window fits yields no result and is dropped on acceptance.
// Kernel registers are written on the cfg channel (index 0 pattern, 1 width,
// 2 height); the user must write them only while the block is idle, which the
// block itself does not enforce; cfg_ready is always high. With the engine
// idle, the first result of a tile passes the queue, stage 1 and the output
// register before out_valid rises. Throughput, set by the window engine: one
// window per cycle unless the output stalls (36 windows: full tile, 3x3 kernel).
// A two-entry job queue lets the front accept tiles while the engine works.
// When out_ready is low the result holds and the engine stalls; the front keeps
// accepting until the queue is full. Reset clears the queue and pipeline and sets
// the kernel to pattern 0, 3x3.
`default_nettype none

module binary_tile_xnor_convolution #(
	parameter int TILE_SIDE = btxc_pkg::TILE_SIDE_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [btxc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [btxc_pkg::TILE_BITS-1:0]      cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [btxc_pkg::TILE_BITS-1:0]      tile_bits,
	input  wire logic [btxc_pkg::DIM_W-1:0]          valid_width,
	input  wire logic [btxc_pkg::DIM_W-1:0]          valid_height,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [btxc_pkg::IDX_W-1:0]               window_row,
	output logic [btxc_pkg::IDX_W-1:0]               window_col,
	output logic signed [btxc_pkg::DOT_W-1:0]        dot_value,
	output logic                                     last
);

	localparam int NROWS = btxc_pkg::TILE_BITS / btxc_pkg::ROW_STRIDE;

	logic [btxc_pkg::TILE_BITS-1:0] kernel_pattern_q;
	logic [btxc_pkg::DIM_W-1:0]     kernel_width_q;
	logic [btxc_pkg::DIM_W-1:0]     kernel_height_q;

	logic [btxc_pkg::DIM_W-1:0]     kw;
	logic [btxc_pkg::DIM_W-1:0]     kh;
	logic [btxc_pkg::ROW_STRIDE-1:0] row_mask;
	logic [btxc_pkg::TILE_BITS-1:0] area_mask;
	logic [2*btxc_pkg::DIM_W-1:0]   area_full;
	btxc_pkg::kernel_t              kcfg;

	logic                           queue_full;
	logic                           push;
	btxc_pkg::job_t                 push_job;
	logic                           pop;
	logic                           head_valid;
	btxc_pkg::job_t                 head;

	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_pattern_q <= '0;
			kernel_width_q   <= btxc_pkg::DIM_W'(3);
			kernel_height_q  <= btxc_pkg::DIM_W'(3);
		end else if (cfg_valid) begin
			unique case (btxc_pkg::cfg_reg_t'(cfg_index))
				btxc_pkg::REG_KERNEL_PATTERN: kernel_pattern_q <= cfg_data;
				btxc_pkg::REG_KERNEL_WIDTH:   kernel_width_q   <= cfg_data[btxc_pkg::DIM_W-1:0];
				btxc_pkg::REG_KERNEL_HEIGHT:  kernel_height_q  <= cfg_data[btxc_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Kernel size clamped to one..tile side
	assign kw = btxc_pkg::clamp_dim(kernel_width_q, btxc_pkg::DIM_W'(1),
		btxc_pkg::DIM_W'(TILE_SIDE));
	assign kh = btxc_pkg::clamp_dim(kernel_height_q, btxc_pkg::DIM_W'(1),
		btxc_pkg::DIM_W'(TILE_SIDE));

	// Kernel area mask and size
	always_comb begin
		for (int i = 0; i < btxc_pkg::ROW_STRIDE; i++) begin
			row_mask[i] = (btxc_pkg::DIM_W'(i) < kw);
		end
		for (int r = 0; r < NROWS; r++) begin
			area_mask[r*btxc_pkg::ROW_STRIDE +: btxc_pkg::ROW_STRIDE] =
				(btxc_pkg::DIM_W'(r) < kh) ? row_mask : '0;
		end
		area_full      = kw * kh;
		kcfg.kern      = kernel_pattern_q & area_mask;
		kcfg.area_mask = area_mask;
		kcfg.area      = area_full[btxc_pkg::AREA_W-1:0];
	end

	btxc_front #(
		.TILE_SIDE(TILE_SIDE)
	) u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.tile_bits   (tile_bits),
		.valid_width (valid_width),
		.valid_height(valid_height),
		.kw          (kw),
		.kh          (kh),
		.queue_full  (queue_full),
		.push        (push),
		.job         (push_job)
	);

	btxc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (queue_full),
		.head_valid(head_valid),
		.head      (head)
	);

	btxc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.kcfg      (kcfg),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.window_row(window_row),
		.window_col(window_col),
		.dot_value (dot_value),
		.last      (last)
	);

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the binary tile XNOR convolution block.
module testbench;
	import btxc_pkg::*;

	localparam int TILE_SIDE   = TILE_SIDE_DEF;
	localparam int DRAIN_SLACK = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_TILES = 355;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	// One expected window result
	typedef struct {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [DOT_W-1:0] dot;
		logic                    is_last;
	} window_result_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [TILE_BITS-1:0]        cfg_data;
	logic                        in_valid;
	logic                        in_ready;
	logic [TILE_BITS-1:0]        tile_bits;
	logic [DIM_W-1:0]            valid_width;
	logic [DIM_W-1:0]            valid_height;
	logic                        out_valid;
	logic                        out_ready;
	logic [IDX_W-1:0]            window_row;
	logic [IDX_W-1:0]            window_col;
	logic signed [DOT_W-1:0]     dot_value;
	logic                        last;

	// Kernel registers as the testbench believes them to be
	logic [TILE_BITS-1:0]        kernel_pattern_q = '0;
	logic [DIM_W-1:0]            kernel_width_q   = 4'd3;
	logic [DIM_W-1:0]            kernel_height_q  = 4'd3;

	window_result_t              pending_windows[$];
	int                          error_count = 0;
	int                          cycle_count;
	int                          hold_cycles = 0;
	bit                          in_gaps_on = 1'b1;
	bit                          out_stalls_on = 1'b1;

	binary_tile_xnor_convolution dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.tile_bits    (tile_bits),
		.valid_width  (valid_width),
		.valid_height (valid_height),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.window_row   (window_row),
		.window_col   (window_col),
		.dot_value    (dot_value),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on total run length
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	function automatic int clamp_size(input logic [DIM_W-1:0] v, input int lo);
		int s;
		s = v;
		if (s < lo)
			s = lo;
		if (s > TILE_SIDE)
			s = TILE_SIDE;
		return s;
	endfunction

	// Queue every window result that one tile produces under the current kernel
	function automatic void predict_windows(input logic [TILE_BITS-1:0] tile,
			input logic [DIM_W-1:0] vw_raw, input logic [DIM_W-1:0] vh_raw);
		int vw, vh, kw, kh, area, ones;
		logic [TILE_BITS-1:0] area_mask, kern, win, match;
		window_result_t res;
		vw = clamp_size(vw_raw, 0);
		vh = clamp_size(vh_raw, 0);
		kw = clamp_size(kernel_width_q, 1);
		kh = clamp_size(kernel_height_q, 1);
		if (kw > vw || kh > vh)
			return;
		area_mask = '0;
		for (int r = 0; r < kh; r++)
			area_mask |= ((64'd1 << kw) - 64'd1) << (r * ROW_STRIDE);
		kern = kernel_pattern_q & area_mask;
		area = kw * kh;
		for (int r = 0; r + kh <= vh; r++) begin
			for (int c = 0; c + kw <= vw; c++) begin
				win         = (tile >> (r * ROW_STRIDE + c)) & area_mask;
				match       = ~(win ^ kern) & area_mask;
				ones        = $countones(match);
				res.row     = IDX_W'(r);
				res.col     = IDX_W'(c);
				res.dot     = DOT_W'(2 * ones - area);
				res.is_last = (r + kh == vh) && (c + kw == vw);
				pending_windows.push_back(res);
			end
		end
	endfunction

	// Result checker: each output transaction against the oldest expectation
	always @(posedge clk) begin : check_windows
		window_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_windows.size() == 0) begin
				report_mismatch($sformatf("unexpected result row %0d col %0d dot %0d",
					window_row, window_col, dot_value));
			end else begin
				want = pending_windows.pop_front();
				if (window_row !== want.row)
					report_mismatch($sformatf("window_row %0d, want %0d", window_row, want.row));
				if (window_col !== want.col)
					report_mismatch($sformatf("window_col %0d, want %0d", window_col, want.col));
				if (dot_value !== want.dot)
					report_mismatch($sformatf("dot_value %0d, want %0d at row %0d col %0d",
						dot_value, want.dot, want.row, want.col));
				if (last !== want.is_last)
					report_mismatch($sformatf("last %b, want %b at row %0d col %0d",
						last, want.is_last, want.row, want.col));
			end
		end
	end

	// Result receiver: random stalls per transaction, long hold-off on request
	initial begin : receiver
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = out_stalls_on ? $urandom_range(0, 4) : 0;
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid && hold_cycles == 0);
		end
	end

	// Offer one tile; valid stays high after acceptance until the next call or a drain
	task automatic send_tile(input logic [TILE_BITS-1:0] tile,
			input logic [DIM_W-1:0] vw, input logic [DIM_W-1:0] vh);
		int gap;
		gap = in_gaps_on ? $urandom_range(0, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		tile_bits    <= tile;
		valid_width  <= vw;
		valid_height <= vh;
		do @(posedge clk); while (!in_ready);
		predict_windows(tile, vw, vh);
	endtask

	// Stop offering tiles and wait for every expected result
	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_windows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// One register write transaction; only called with the block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TILE_BITS-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_KERNEL_PATTERN: kernel_pattern_q = data;
			REG_KERNEL_WIDTH:   kernel_width_q   = data[DIM_W-1:0];
			REG_KERNEL_HEIGHT:  kernel_height_q  = data[DIM_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Size write with junk in the unused upper bits
	task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input int size);
		logic [TILE_BITS-1:0] data;
		data = {$urandom, $urandom};
		data[DIM_W-1:0] = DIM_W'(size);
		write_reg(idx, data);
	endtask

	function automatic logic [TILE_BITS-1:0] random_tile();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// Mostly small kernels, some large, some out of range
	function automatic int draw_kernel_size();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return $urandom_range(1, 4);
		if (pick < 8)
			return $urandom_range(5, 8);
		if (pick == 8)
			return $urandom_range(0, 15);
		return TILE_SIDE;
	endfunction

	// Kernel left at its reset value: zero pattern, 3x3
	task automatic test_reset_kernel();
		send_tile('0, 4'd8, 4'd8);
		send_tile('1, 4'd8, 4'd8);
	endtask

	// Valid area corners: exact fit, too small, zero, oversized
	task automatic test_tile_edges();
		send_tile(random_tile(), 4'd3, 4'd3);
		send_tile(random_tile(), 4'd2, 4'd8);
		send_tile(random_tile(), 4'd0, 4'd5);
		send_tile(random_tile(), 4'd15, 4'd15);
		send_tile(random_tile(), 4'd8, 4'd0);
		send_tile(64'hAAAA_AAAA_AAAA_AAAA, 4'd9, 4'd12);
		wait_drain();
	endtask

	// Kernel size corners, the dot product extremes and an unmapped register
	task automatic test_kernel_sizes();
		logic [TILE_BITS-1:0] pattern;
		pattern = {$urandom, $urandom};
		write_reg(REG_KERNEL_PATTERN, '1);
		write_size(REG_KERNEL_WIDTH, 0);
		write_size(REG_KERNEL_HEIGHT, 15);
		send_tile(random_tile(), 4'd8, 4'd8);
		wait_drain();
		write_reg(REG_KERNEL_PATTERN, pattern);
		write_size(REG_KERNEL_WIDTH, 8);
		write_size(REG_KERNEL_HEIGHT, 8);
		send_tile(pattern, 4'd8, 4'd8);
		send_tile(~pattern, 4'd8, 4'd8);
		wait_drain();
		write_size(REG_KERNEL_WIDTH, 9);
		write_size(REG_KERNEL_HEIGHT, 0);
		send_tile(random_tile(), 4'd8, 4'd8);
		wait_drain();
		write_size(REG_KERNEL_WIDTH, 1);
		write_size(REG_KERNEL_HEIGHT, 1);
		send_tile(random_tile(), 4'd8, 4'd8);
		wait_drain();
		write_reg(REG_UNMAPPED, '1);
		send_tile(random_tile(), 4'd4, 4'd4);
		wait_drain();
		write_reg(REG_KERNEL_PATTERN, 64'h5555_5555_5555_5555);
		write_size(REG_KERNEL_WIDTH, 5);
		write_size(REG_KERNEL_HEIGHT, 2);
		send_tile(random_tile(), 4'd7, 4'd6);
		wait_drain();
	endtask

	// Receiver holds off while full tiles keep coming, so the input must stall
	task automatic test_backpressure();
		write_reg(REG_KERNEL_PATTERN, {$urandom, $urandom});
		write_size(REG_KERNEL_WIDTH, 1);
		write_size(REG_KERNEL_HEIGHT, 1);
		in_gaps_on = 1'b0;
		hold_cycles = 300;
		repeat (8) send_tile(random_tile(), 4'd8, 4'd8);
		wait_drain();
		in_gaps_on = 1'b1;
	endtask

	// Phases of random tiles, kernel registers rewritten at random per phase, draining in between
	task automatic test_random_tiles(input int item_total);
		int sent, phase_len, kw, kh, vw, vh;
		sent = 0;
		while (sent < item_total) begin
			wait_drain();
			in_gaps_on    = ($urandom_range(0, 3) != 0);
			out_stalls_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_KERNEL_PATTERN, random_tile());
			if ($urandom_range(0, 3) != 0)
				write_size(REG_KERNEL_WIDTH, draw_kernel_size());
			if ($urandom_range(0, 3) != 0)
				write_size(REG_KERNEL_HEIGHT, draw_kernel_size());
			if ($urandom_range(0, 15) == 0)
				write_reg(REG_UNMAPPED, {$urandom, $urandom});
			kw = clamp_size(kernel_width_q, 1);
			kh = clamp_size(kernel_height_q, 1);
			phase_len = $urandom_range(10, 30);
			repeat (phase_len) begin
				// mostly areas the kernel fits into, the rest anything
				vw = ($urandom_range(0, 9) < 8) ? $urandom_range(kw, TILE_SIDE) : $urandom_range(0, 15);
				vh = ($urandom_range(0, 9) < 8) ? $urandom_range(kh, TILE_SIDE) : $urandom_range(0, 15);
				send_tile(random_tile(), DIM_W'(vw), DIM_W'(vh));
				sent++;
			end
		end
		wait_drain();
		in_gaps_on    = 1'b1;
		out_stalls_on = 1'b1;
	endtask

	initial begin
		cfg_valid    = 1'b0;
		cfg_index    = REG_KERNEL_PATTERN;
		cfg_data     = '0;
		in_valid     = 1'b0;
		tile_bits    = '0;
		valid_width  = '0;
		valid_height = '0;
		arst_n       = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_kernel();
		test_tile_edges();
		test_kernel_sizes();
		test_backpressure();
		test_random_tiles(RANDOM_TILES);

		wait_drain();
		if (error_count == 0 && pending_windows.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
